// ===== rtl/spqt_pkg.sv =====
// ----------------------------------------------------------------------------
// spqt_pkg - shared types and constants for the presence qualifier
// Holds the register file layout, reset values and the result word layout.
// ----------------------------------------------------------------------------
package spqt_pkg;

    localparam int CLEAR_LEVEL_W = 12;
    localparam int CONFIRM_W     = 10;
    localparam int TIMEOUT_W     = 24;
    localparam int BLINK_W       = 10;
    localparam int TICK_W        = 24;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int RESULT_W      = 4;
    localparam int OUT_TDATA_W   = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF  = 2'd3;

    // Reset values
    localparam logic [CLEAR_LEVEL_W-1:0] CLEAR_LEVEL_RST = 12'd4095;
    localparam logic [CONFIRM_W-1:0]     CONFIRM_RST     = 10'd20;
    localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST     = 24'd3000000;
    localparam logic [BLINK_W-1:0]       BLINK_HALF_RST  = 10'd200;

    typedef struct packed {
        logic [CLEAR_LEVEL_W-1:0] clear_level;
        logic [CONFIRM_W-1:0]     confirm_ticks;
        logic [TIMEOUT_W-1:0]     timeout_ticks;
        logic [BLINK_W-1:0]       blink_half_ticks;
    } cfg_t;

    // Packed so that detected lands in bit 0
    typedef struct packed {
        logic backlight_on;
        logic buzzer_on;
        logic stuck_alarm;
        logic detected;
    } result_t;

endpackage

// ===== rtl/spqt_step.sv =====
// ----------------------------------------------------------------------------
// spqt_step - per-tick state machine of the presence qualifier
// Holds mode, tick counter and blink phase; gives the result of one tick.
// ----------------------------------------------------------------------------
module spqt_step
    import spqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  logic    low,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CONFIRM,
        MODE_WAIT,
        MODE_ALARM
    } mode_t;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic               phase_reg;
    logic               phase_next;
    logic [TICK_W-1:0]  tick_inc;
    logic [BLINK_W-1:0] half;

    assign tick_inc = tick_reg + TICK_W'(1);
    assign half     = (cfg.blink_half_ticks == '0) ? BLINK_W'(1) : cfg.blink_half_ticks;

    always_comb
    begin
        mode_next        = mode_reg;
        tick_next        = tick_reg;
        phase_next       = phase_reg;
        res.detected     = 1'b0;
        res.stuck_alarm  = 1'b0;
        res.buzzer_on    = 1'b0;
        res.backlight_on = 1'b1;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (low)
                begin
                    tick_next = '0;
                    mode_next = (cfg.confirm_ticks == '0) ? MODE_WAIT : MODE_CONFIRM;
                end
            end
            MODE_CONFIRM:
            begin
                tick_next = tick_inc;
                if (tick_inc >= TICK_W'(cfg.confirm_ticks))
                begin
                    tick_next = '0;
                    mode_next = low ? MODE_WAIT : MODE_IDLE;
                end
            end
            MODE_WAIT:
            begin
                if (!low)
                begin
                    res.detected = (tick_reg < cfg.timeout_ticks);
                    tick_next    = '0;
                    mode_next    = MODE_IDLE;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.timeout_ticks)
                    begin
                        tick_next  = '0;
                        phase_next = 1'b0;
                        mode_next  = MODE_ALARM;
                    end
                end
            end
            MODE_ALARM:
            begin
                // Leave only at the start of a blink cycle once the sensor is clear
                if (tick_reg == '0 && !phase_reg && !low)
                begin
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    res.stuck_alarm  = 1'b1;
                    res.buzzer_on    = !phase_reg;
                    res.backlight_on = phase_reg;
                    tick_next        = tick_inc;
                    if (tick_inc >= TICK_W'(half))
                    begin
                        tick_next  = '0;
                        phase_next = !phase_reg;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            tick_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else if (go)
        begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
        end
    end

    a_idle_clear_stays: assert property (@(posedge clk) disable iff (!rst_n)
        go && mode_reg == MODE_IDLE && !low |=> mode_reg == MODE_IDLE)
        else $error("idle left on a clear sample");

    a_wait_clear_returns: assert property (@(posedge clk) disable iff (!rst_n)
        go && mode_reg == MODE_WAIT && !low |=> mode_reg == MODE_IDLE && tick_reg == '0)
        else $error("clear sample in wait did not return to idle");

    a_buzz_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        res.buzzer_on |-> res.stuck_alarm && !res.backlight_on && !res.detected)
        else $error("buzzer driven outside alarm");

    a_phase_only_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != $past(phase_reg) |-> $past(go)
            && ($past(mode_reg) == MODE_ALARM || $past(mode_reg) == MODE_WAIT))
        else $error("blink phase moved outside alarm");

endmodule

// ===== rtl/sensor_presence_qualifier_timeout_core.sv =====
// ----------------------------------------------------------------------------
// sensor_presence_qualifier_timeout_core - debounced presence detector
// Qualifies sensor samples, pulses on a confirmed pass, blinks a stuck alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one sample per time tick on the slave stream (s_tvalid/s_tready/
//   s_tdata). Every sample gives exactly one result on the master stream:
//   m_tdata bit 0 detected, bit 1 stuck_alarm, bit 2 buzzer_on,
//   bit 3 backlight_on. Tick counting follows accepted transfers, not clock
//   cycles, so the caller sets the tick rate.
//   Configuration is a write port (cfg_wr_en, cfg_index, cfg_data): index 0
//   clear level, 1 confirm ticks, 2 timeout ticks, 3 blink half ticks. Write
//   only while no sample is in flight; a write takes effect on the next tick.
//   Pipeline: a captured sample's result is loaded into the output register
//   once that stage is free. Throughput: one sample per cycle while m_tready
//   stays high, set by the single compare and counter update between the two
//   registers. Stall: when m_tready is low the result holds; the input
//   register takes one more sample only if empty, then s_tready drops until
//   the result moves. Reset (rst_n low, asynchronous) empties both stages,
//   returns the state machine to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module sensor_presence_qualifier_timeout_core
    import spqt_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // detected, stuck_alarm, buzzer_on, backlight_on
    output logic [OUT_TDATA_W-1:0]                  m_tdata,
    input  logic                                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                   cfg_data
);

    localparam int CMP_W = (SAMPLE_BITS > CLEAR_LEVEL_W) ? SAMPLE_BITS : CLEAR_LEVEL_W;

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    result_t                res_reg;
    result_t                step_res;
    logic                   advance;
    logic                   go;
    logic                   low;

    // Output stage frees up when empty or when its result is taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign go       = in_valid_reg && advance;
    assign low      = CMP_W'(sample_reg) < CMP_W'(cfg_reg.clear_level);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clear_level      <= CLEAR_LEVEL_RST;
            cfg_reg.confirm_ticks    <= CONFIRM_RST;
            cfg_reg.timeout_ticks    <= TIMEOUT_RST;
            cfg_reg.blink_half_ticks <= BLINK_HALF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CLEAR_LEVEL: cfg_reg.clear_level      <= cfg_data[CLEAR_LEVEL_W-1:0];
                REG_CONFIRM:     cfg_reg.confirm_ticks    <= cfg_data[CONFIRM_W-1:0];
                REG_TIMEOUT:     cfg_reg.timeout_ticks    <= cfg_data[TIMEOUT_W-1:0];
                REG_BLINK_HALF:  cfg_reg.blink_half_ticks <= cfg_data[BLINK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register: capture a sample on each slave transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    spqt_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .low   (low),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    // Result register: hold while the master side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_reg};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the presence qualifier core
// Streams sensor samples into the core and holds a cycle-free model of the
// qualifier state machine. The model runs once per accepted sample, and each
// result the core emits is checked flag by flag against the oldest predicted
// result. Directed tests cover the reset defaults, the zero waits, the recheck,
// the stuck alarm and its exit, and the level extremes. A random part follows,
// built mostly from object passes with random content, with bursty input and a
// patterned output stall.
// ----------------------------------------------------------------------------
module tb;
    import spqt_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int S_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1650;
    // Longest quiet stretch: slow stall pattern plus a sender gap, or a
    // register update, or the drain at the end; taken well over.
    localparam int QUIET_LIMIT  = 400;

    typedef enum logic [1:0] {ST_IDLE, ST_CONFIRM, ST_WAIT_CLEAR, ST_ALARM} det_mode_t;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_COMB, RX_SLOW} rx_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;     // sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // detected, stuck_alarm, buzzer_on, backlight_on, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow of the qualifier: registers and state machine
    cfg_t              shadow_cfg;
    det_mode_t         shadow_mode;
    logic [TICK_W-1:0] shadow_tick;
    logic              shadow_phase;

    result_t   flags_due[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        items_sent = 0;
    int        quiet_cycles = 0;
    int        burst_left = 0;
    bit        gaps_on = 1'b0;
    rx_style_t rx_style = RX_OPEN;
    int        rx_tick = 0;

    sensor_presence_qualifier_timeout_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Qualifier model: advance one tick for an accepted sample and return the
    // flags that tick produces.
    // ------------------------------------------------------------------------
    function automatic result_t qualify_sample(input logic [SAMPLE_BITS-1:0] s);
        result_t            r;
        logic               lo;
        logic [BLINK_W-1:0] half;
        begin
            r = '0;
            r.backlight_on = 1'b1;
            lo = s < shadow_cfg.clear_level;
            // a zero half period behaves as one tick
            half = (shadow_cfg.blink_half_ticks == '0) ? BLINK_W'(1)
                                                       : shadow_cfg.blink_half_ticks;
            case (shadow_mode)
                ST_IDLE:
                begin
                    if (lo)
                    begin
                        shadow_tick = '0;
                        shadow_mode = (shadow_cfg.confirm_ticks == '0) ? ST_WAIT_CLEAR
                                                                       : ST_CONFIRM;
                    end
                end
                ST_CONFIRM:
                begin
                    shadow_tick = shadow_tick + TICK_W'(1);
                    if (shadow_tick >= TICK_W'(shadow_cfg.confirm_ticks))
                    begin
                        shadow_tick = '0;
                        shadow_mode = lo ? ST_WAIT_CLEAR : ST_IDLE;
                    end
                end
                ST_WAIT_CLEAR:
                begin
                    if (!lo)
                    begin
                        // a pass only counts if it ended before the timeout
                        r.detected  = shadow_tick < shadow_cfg.timeout_ticks;
                        shadow_tick = '0;
                        shadow_mode = ST_IDLE;
                    end
                    else
                    begin
                        shadow_tick = shadow_tick + TICK_W'(1);
                        if (shadow_tick >= shadow_cfg.timeout_ticks)
                        begin
                            shadow_tick  = '0;
                            shadow_phase = 1'b0;
                            shadow_mode  = ST_ALARM;
                        end
                    end
                end
                default:
                begin
                    // the alarm only looks at the sample at the start of a blink
                    if (shadow_tick == '0 && !shadow_phase && !lo)
                    begin
                        shadow_mode = ST_IDLE;
                    end
                    else
                    begin
                        r.stuck_alarm  = 1'b1;
                        r.buzzer_on    = !shadow_phase;
                        r.backlight_on = shadow_phase;
                        shadow_tick = shadow_tick + TICK_W'(1);
                        if (shadow_tick >= TICK_W'(half))
                        begin
                            shadow_tick  = '0;
                            shadow_phase = ~shadow_phase;
                        end
                    end
                end
            endcase
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("MISMATCH result %0d %s: got %0d want %0d",
                     results_seen, what, got, want);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output checker: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (flags_due.size() == 0)
            begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end
            else
            begin
                want = flags_due.pop_front();
                if (got.detected !== want.detected)
                    report_mismatch("detected", int'(got.detected), int'(want.detected));
                if (got.stuck_alarm !== want.stuck_alarm)
                    report_mismatch("stuck_alarm", int'(got.stuck_alarm),
                                    int'(want.stuck_alarm));
                if (got.buzzer_on !== want.buzzer_on)
                    report_mismatch("buzzer_on", int'(got.buzzer_on), int'(want.buzzer_on));
                if (got.backlight_on !== want.backlight_on)
                    report_mismatch("backlight_on", int'(got.backlight_on),
                                    int'(want.backlight_on));
                if (m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0)
                    report_mismatch("zero fill", int'(m_tdata[OUT_TDATA_W-1:RESULT_W]), 0);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on the pattern picked for the current stretch
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            RX_COMB:   m_tready <= (rx_tick % 7) < 4;
            default:   m_tready <= (rx_tick % 20) >= 12;
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: one sample transfer, in bursts with random gaps between them.
    // Valid stays high across back-to-back samples and is lowered only for a gap.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = gaps_on ? $urandom_range(0, 5) : 0;
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= S_TDATA_W'(v);
            do @(posedge clk); while (!s_tready);
            // accepted at this edge: advance the model
            flags_due.push_back(qualify_sample(v));
            items_sent++;
        end
    endtask

    task automatic send_run(input logic [SAMPLE_BITS-1:0] v, input int count);
        begin
            repeat (count) send_sample(v);
        end
    endtask

    // Hold the sender off until every predicted result has been checked
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while (flags_due.size() != 0);
        end
    endtask

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    // Drain the core, then write all four registers; bits above a register's
    // width are dropped by the core, so drop them in the model too.
    task automatic set_regs(input logic [CFG_DATA_W-1:0] clr,
                            input logic [CFG_DATA_W-1:0] cnf,
                            input logic [CFG_DATA_W-1:0] tmo,
                            input logic [CFG_DATA_W-1:0] blk);
        begin
            drain();
            write_one(REG_CLEAR_LEVEL, clr);
            write_one(REG_CONFIRM, cnf);
            write_one(REG_TIMEOUT, tmo);
            write_one(REG_BLINK_HALF, blk);
            cfg_wr_en <= 1'b0;
            shadow_cfg.clear_level      = clr[CLEAR_LEVEL_W-1:0];
            shadow_cfg.confirm_ticks    = cnf[CONFIRM_W-1:0];
            shadow_cfg.timeout_ticks    = tmo[TIMEOUT_W-1:0];
            shadow_cfg.blink_half_ticks = blk[BLINK_W-1:0];
            @(posedge clk);
        end
    endtask

    // Samples on either side of the clear level, often right at the boundary
    function automatic logic [SAMPLE_BITS-1:0] low_sample();
        begin
            if (shadow_cfg.clear_level == '0)
                return SAMPLE_BITS'($urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0)
                return shadow_cfg.clear_level - CLEAR_LEVEL_W'(1);
            return SAMPLE_BITS'($urandom_range(0, int'(shadow_cfg.clear_level) - 1));
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clear_sample();
        begin
            if ($urandom_range(0, 3) == 0)
                return shadow_cfg.clear_level;
            return SAMPLE_BITS'($urandom_range(int'(shadow_cfg.clear_level), 4095));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Default level and confirm wait: a full pass detected with no writes
    task automatic test_reset_defaults();
        begin
            rx_style = RX_OPEN;
            gaps_on  = 1'b0;
            send_sample(12'hFFF);       // at the level: clear
            send_sample(12'hFFE);       // just below: start the confirm wait
            send_run(12'h000, 19);      // confirm ticks 1 to 19
            send_sample(12'hAAA);       // recheck still low
            send_sample(12'h555);
            send_sample(12'hFFF);       // clears: detection
        end
    endtask

    // No confirm wait, then a timeout into the alarm; leave it right away once,
    // and once at the end of a blink cycle with a clear sample in the dark half
    task automatic test_zero_confirm_and_stuck_alarm();
        begin
            set_regs(24'd2048, 24'd0, 24'd3, 24'd2);
            rx_style = RX_RANDOM;
            gaps_on  = 1'b1;
            send_sample(12'd2047);
            send_sample(12'd2048);
            send_run(12'd0, 4);
            send_sample(12'd4095);      // first alarm tick already clear
            send_run(12'd0, 5);
            send_run(12'd4095, 4);
        end
    endtask

    // Recheck finds the sample clear: back to idle without a detection
    task automatic test_recheck_clear();
        begin
            set_regs(24'd100, 24'd2, 24'd10, 24'd1);
            rx_style = RX_COMB;
            send_sample(12'd99);
            send_sample(12'd4000);
            send_sample(12'd100);
            send_run(12'd50, 3);
            send_sample(12'd100);
        end
    endtask

    // Zero timeout never detects; zero half period blinks every tick
    task automatic test_zero_timeout_and_blink();
        begin
            set_regs(24'd4095, 24'd0, 24'd0, 24'd0);
            rx_style = RX_SLOW;
            send_sample(12'd0);
            send_sample(12'd4095);
            send_run(12'd0, 5);
            send_run(12'd4095, 2);
        end
    endtask

    // Level extremes; upper data bits beyond a register's width are ignored
    task automatic test_level_extremes();
        begin
            set_regs(24'hFFF000, 24'hFFFC01, 24'd5, 24'hABC002);
            rx_style = RX_RANDOM;
            send_sample(12'h000);       // clear level zero: nothing is low
            send_sample(12'h800);
            set_regs(24'd4095, 24'd1, 24'd5, 24'd1);
            send_sample(12'hFFF);
            send_sample(12'hFFE);
            send_sample(12'h7FF);
            send_sample(12'hFFF);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly clean passes with random lengths, some broken
    // sequences and noise; a new register setting and stall pattern per phase.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int                    phase;
        int                    start;
        int                    stop_at;
        int                    kind;
        int                    n;
        int                    span;
        int                    half;
        logic [CFG_DATA_W-1:0] clr;
        logic [CFG_DATA_W-1:0] cnf;
        logic [CFG_DATA_W-1:0] tmo;
        logic [CFG_DATA_W-1:0] blk;
        begin
            phase = 0;
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS)
            begin
                case (phase)
                    0:
                    begin
                        clr = 24'd4095; cnf = 24'd1023; tmo = 24'hFFFFFF; blk = 24'd1023;
                    end
                    1:
                    begin
                        clr = 24'd1; cnf = 24'd0; tmo = 24'd1; blk = 24'd1;
                    end
                    2:
                    begin
                        clr = 24'd0; cnf = 24'd3; tmo = 24'd4; blk = 24'd2;
                    end
                    default:
                    begin
                        clr = ($urandom_range(0, 9) == 0) ? 24'd4095
                                                          : CFG_DATA_W'($urandom_range(1, 4095));
                        cnf = CFG_DATA_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4)
                                                                      : $urandom_range(5, 40));
                        n = $urandom_range(0, 9);
                        tmo = (n == 0) ? 24'd0
                                       : CFG_DATA_W'((n < 7) ? $urandom_range(1, 20)
                                                             : $urandom_range(21, 90));
                        blk = CFG_DATA_W'($urandom_range(0, 6));
                        if ($urandom_range(0, 3) == 0)
                        begin
                            clr = clr | (CFG_DATA_W'($urandom) & 24'hFFF000);
                            cnf = cnf | (CFG_DATA_W'($urandom) & 24'hFFFC00);
                            blk = blk | (CFG_DATA_W'($urandom) & 24'hFFFC00);
                        end
                    end
                endcase
                set_regs(clr, cnf, tmo, blk);
                rx_style = rx_style_t'($urandom_range(0, 3));
                gaps_on  = ($urandom_range(0, 3) != 0);
                half = (shadow_cfg.blink_half_ticks == '0) ? 1
                                                           : int'(shadow_cfg.blink_half_ticks);
                span = int'(shadow_cfg.confirm_ticks) + int'(shadow_cfg.timeout_ticks)
                       + 4 * half + 4;
                if (span > 150)
                    span = 150;
                stop_at = items_sent + ((phase < 3) ? 50 : 130);
                while (items_sent < stop_at)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind < 7)
                    begin
                        // object pass: clear lead, low stretch, long enough clear tail
                        repeat ($urandom_range(1, 3)) send_sample(clear_sample());
                        repeat ($urandom_range(0, span)) send_sample(low_sample());
                        repeat ($urandom_range(1, 2 * half + 2)) send_sample(clear_sample());
                    end
                    else if (kind < 9)
                    begin
                        // flicker around the level
                        repeat ($urandom_range(1, 20))
                            send_sample(($urandom_range(0, 1) != 0) ? low_sample()
                                                                    : clear_sample());
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 20))
                            send_sample(SAMPLE_BITS'($urandom_range(0, 4095)));
                    end
                    if ($urandom_range(0, 19) == 0)
                        drain();
                end
                phase++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        shadow_cfg.clear_level      = CLEAR_LEVEL_RST;
        shadow_cfg.confirm_ticks    = CONFIRM_RST;
        shadow_cfg.timeout_ticks    = TIMEOUT_RST;
        shadow_cfg.blink_half_ticks = BLINK_HALF_RST;
        shadow_mode  = ST_IDLE;
        shadow_tick  = '0;
        shadow_phase = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_confirm_and_stuck_alarm();
        test_recheck_clear();
        test_zero_timeout_and_blink();
        test_level_extremes();
        test_random_traffic();

        // wait for the last results, then keep running to catch anything stray
        s_tvalid <= 1'b0;
        do @(posedge clk); while (flags_due.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spqt_pkg.sv
rtl/spqt_step.sv
rtl/sensor_presence_qualifier_timeout_core.sv
test/tb.sv
